### src/assert_macros.svh
// Assertion macros used by the escape-time iterator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define ETF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etf assertion failed");

// Implication checked in the cycle after the antecedent, disabled while reset is asserted.
`define ETF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etf assertion failed");

`endif

### src/etf_pkg.sv
// Package with types, constants and width helpers of the escape-time iterator.
package etf_pkg;

    localparam int IN_W           = 31;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int COUNT_BITS_DEF = 10;
    localparam int LIMIT_RESET    = 50;
    localparam logic SHIP_RESET   = 1'b0;

    typedef enum logic [0:0] {
        REG_ITER_LIMIT,
        REG_SHIP_MODE
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MRR,
        ST_MII,
        ST_MRI,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel sel;
        logic     cap_rr;
        logic     cap_ii;
        logic     upd;
    } t_dp_ctrl;

    // Magnitude bits needed for any z component: covers the first step from an
    // arbitrary start point and every step from a point inside radius two.
    function automatic int etf_mag_w(int frac);
        int b;
        b = 2 * IN_W - 1 - frac;
        if (frac + 3 > b) b = frac + 3;
        if (IN_W - 1 > b) b = IN_W - 1;
        return b + 1;
    endfunction

endpackage

### src/etf_pix_if.sv
// Input channel interface carrying one pixel's start point and constant.
interface etf_pix_if;
    import etf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] start_real;
    logic signed [IN_W-1:0] start_imag;
    logic signed [IN_W-1:0] const_real;
    logic signed [IN_W-1:0] const_imag;

    modport source (
        output valid, start_real, start_imag, const_real, const_imag,
        input  ready
    );

    modport sink (
        input  valid, start_real, start_imag, const_real, const_imag,
        output ready
    );
endinterface

### src/etf_res_if.sv
// Result channel interface carrying the escape iteration and escaped flag.
interface etf_res_if #(
    parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] iteration_count;
    logic                  escaped;

    modport source (
        output valid, iteration_count, escaped,
        input  ready
    );

    modport sink (
        input  valid, iteration_count, escaped,
        output ready
    );
endinterface

### src/etf_mult.sv
// Shared unsigned multiplier with a registered product.
module etf_mult #(
    parameter int A_W = 34
) (
    input  logic             i_clk,
    input  logic [A_W-1:0]   i_a,
    input  logic [A_W-1:0]   i_b,
    output logic [2*A_W-1:0] o_prod
);
    logic [2*A_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

### src/etf_dpath.sv
// Datapath: z and c registers, product capture, update adders and escape test.
module etf_dpath #(
    parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF,
    parameter int MAG_W     = etf_pkg::etf_mag_w(etf_pkg::FRAC_BITS_DEF)
) (
    input  logic                           i_clk,
    input  etf_pkg::t_dp_ctrl              i_ctl,
    input  logic                           i_ship,
    input  logic signed [etf_pkg::IN_W-1:0] i_start_re,
    input  logic signed [etf_pkg::IN_W-1:0] i_start_im,
    input  logic signed [etf_pkg::IN_W-1:0] i_const_re,
    input  logic signed [etf_pkg::IN_W-1:0] i_const_im,
    output logic                           o_escape
);
    import etf_pkg::*;

    localparam int Z_W = MAG_W + 1;
    localparam int P_W = 2 * MAG_W;
    localparam int S_W = P_W + 3;
    localparam logic [P_W:0] FOUR = (P_W + 1)'(1) << (2 * FRAC_BITS + 2);

    logic signed [Z_W-1:0]  r_zr;
    logic signed [Z_W-1:0]  r_zi;
    logic signed [IN_W-1:0] r_cr;
    logic signed [IN_W-1:0] r_ci;
    logic [P_W-1:0]         r_rr;
    logic [P_W-1:0]         r_ii;
    logic [P_W-1:0]         prod;

    logic signed [Z_W-1:0]  neg_re;
    logic signed [Z_W-1:0]  neg_im;
    logic [MAG_W-1:0]       abs_re;
    logic [MAG_W-1:0]       abs_im;
    logic [MAG_W-1:0]       mul_a;
    logic [MAG_W-1:0]       mul_b;

    logic signed [S_W-1:0]  c_re_w;
    logic signed [S_W-1:0]  c_im_w;
    logic signed [S_W-1:0]  rr_w;
    logic signed [S_W-1:0]  ii_w;
    logic signed [S_W-1:0]  prod_w;
    logic signed [S_W-1:0]  ri_w;
    logic signed [S_W-1:0]  sum_re;
    logic signed [S_W-1:0]  sum_im;
    logic signed [S_W-1:0]  sh_re;
    logic signed [S_W-1:0]  sh_im;
    logic                   ri_neg;
    logic [P_W:0]           mag_sum;

    assign neg_re = -r_zr;
    assign neg_im = -r_zi;
    assign abs_re = r_zr[Z_W-1] ? neg_re[MAG_W-1:0] : r_zr[MAG_W-1:0];
    assign abs_im = r_zi[Z_W-1] ? neg_im[MAG_W-1:0] : r_zi[MAG_W-1:0];

    always_comb begin
        unique case (i_ctl.sel)
            MUL_RR: begin
                mul_a = abs_re;
                mul_b = abs_re;
            end
            MUL_II: begin
                mul_a = abs_im;
                mul_b = abs_im;
            end
            MUL_RI: begin
                mul_a = abs_re;
                mul_b = abs_im;
            end
            default: begin
                mul_a = abs_re;
                mul_b = abs_im;
            end
        endcase
    end

    etf_mult #(
        .A_W (MAG_W)
    ) u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign c_re_w = S_W'(r_cr) <<< FRAC_BITS;
    assign c_im_w = S_W'(r_ci) <<< FRAC_BITS;
    assign rr_w   = S_W'(r_rr);
    assign ii_w   = S_W'(r_ii);
    assign prod_w = S_W'(prod);
    assign ri_neg = (r_zr[Z_W-1] ^ r_zi[Z_W-1]) & ~i_ship;
    assign ri_w   = ri_neg ? -prod_w : prod_w;
    assign sum_re = rr_w - ii_w + c_re_w;
    assign sum_im = (ri_w <<< 1) + c_im_w;
    assign sh_re  = sum_re >>> FRAC_BITS;
    assign sh_im  = sum_im >>> FRAC_BITS;

    assign mag_sum  = {1'b0, r_rr} + {1'b0, prod};
    assign o_escape = mag_sum > FOUR;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_zr <= Z_W'(i_start_re);
            r_zi <= Z_W'(i_start_im);
            r_cr <= i_const_re;
            r_ci <= i_const_im;
        end else if (i_ctl.upd) begin
            r_zr <= sh_re[Z_W-1:0];
            r_zi <= sh_im[Z_W-1:0];
        end
        if (i_ctl.cap_rr) begin
            r_rr <= prod;
        end
        if (i_ctl.cap_ii) begin
            r_ii <= prod;
        end
    end
endmodule

### src/etf_ctrl.sv
// Sequencer: iteration FSM, iteration counter and output register.
`include "assert_macros.svh"

module etf_ctrl #(
    parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COUNT_BITS-1:0] o_out_count,
    output logic                  o_out_escaped,
    input  logic [COUNT_BITS-1:0] i_limit,
    input  logic                  i_escape,
    output etf_pkg::t_dp_ctrl     o_ctl
);
    import etf_pkg::*;

    t_state                r_state;
    t_state                n_state;
    t_dp_ctrl              ctl;
    logic                  in_ready;
    logic                  out_load;
    logic                  is_last;
    logic                  r_first;
    logic [COUNT_BITS-1:0] r_iter;
    logic [COUNT_BITS-1:0] r_res_count;
    logic                  r_res_esc;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_esc;

    assign is_last = (r_iter == i_limit - COUNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_limit == '0) ? ST_DONE : ST_MRR;
                end
            end
            ST_MRR: n_state = ST_MII;
            ST_MII: n_state = ST_MRI;
            ST_MRI: begin
                if (!r_first && (i_escape || is_last)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: n_state = ST_MRR;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl      = '0;
        ctl.sel  = MUL_RR;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                ctl.load = i_in_valid;
            end
            ST_MRR: ctl.sel = MUL_RR;
            ST_MII: begin
                ctl.sel    = MUL_II;
                ctl.cap_rr = 1'b1;
            end
            ST_MRI: begin
                ctl.sel    = MUL_RI;
                ctl.cap_ii = 1'b1;
            end
            ST_UPD: ctl.upd = 1'b1;
            ST_DONE: out_load = !r_out_valid || i_out_ready;
            default: ctl.sel = MUL_RR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.load) begin
                r_iter  <= '0;
                r_first <= 1'b1;
            end else if (r_state == ST_MRI) begin
                if (r_first) begin
                    r_first <= 1'b0;
                end else if (!i_escape && !is_last) begin
                    r_iter <= r_iter + COUNT_BITS'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_res_count <= '0;
            r_res_esc   <= 1'b0;
        end else if (r_state == ST_MRI && !r_first) begin
            if (i_escape) begin
                r_res_count <= r_iter;
                r_res_esc   <= 1'b1;
            end else if (is_last) begin
                r_res_count <= i_limit;
                r_res_esc   <= 1'b0;
            end
        end
        if (out_load) begin
            r_out_count <= r_res_count;
            r_out_esc   <= r_res_esc;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_out_count   = r_out_count;
    assign o_out_escaped = r_out_esc;
    assign o_ctl         = ctl;

    `ETF_ASSERT_NXT(a_mri_exit, i_clk, i_rst_n, r_state == ST_MRI,
        r_state == ST_UPD || r_state == ST_DONE)
    `ETF_ASSERT_IMP(a_upd_not_first, i_clk, i_rst_n, r_state == ST_UPD, !r_first)
    `ETF_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, out_load, r_out_valid)
    `ETF_ASSERT_NXT(a_done_waits, i_clk, i_rst_n,
        r_state == ST_DONE && r_out_valid && !i_out_ready, r_state == ST_DONE)
endmodule

### src/escape_time_fractal_iterate_top.sv
// Top level of the escape-time fractal iterator with its configuration registers.
//
//   Channel   Direction  Contents
//   i_pix     in         start_real, start_imag, const_real, const_imag
//   o_res     out        iteration_count, escaped
//   i_cfg_*   in         iteration_limit (index 0), burning_ship_mode (index 1)
//
// Each iteration uses the one shared multiplier in turn: re*re, im*im
// with the escape test, re*im, then the update of z.
// A pixel occupies the block from accept until its result is loaded into the
// output register; an iteration limit of zero skips the iterations.
// The result waits in an output register, so a stalled sink holds off the next
// transaction only once a second result is finished.
// Reset is synchronous and active low; it sets the limit to 50 and plain mode.
module escape_time_fractal_iterate_top #(
    parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = etf_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    etf_pix_if.sink               i_pix,
    etf_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  etf_pkg::t_cfg_reg     i_cfg_idx,
    input  logic [COUNT_BITS-1:0] i_cfg_data
);
    import etf_pkg::*;

    localparam int MAG_W = etf_mag_w(FRAC_BITS);

    logic [COUNT_BITS-1:0] r_limit;
    logic                  r_ship;
    t_dp_ctrl              ctl;
    logic                  escape;
    logic                  in_ready;
    logic                  out_valid;
    logic [COUNT_BITS-1:0] out_count;
    logic                  out_escaped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= COUNT_BITS'(LIMIT_RESET);
            r_ship  <= SHIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ITER_LIMIT: r_limit <= i_cfg_data;
                REG_SHIP_MODE:  r_ship  <= i_cfg_data[0];
            endcase
        end
    end

    etf_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_pix.valid),
        .o_in_ready    (in_ready),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (out_valid),
        .o_out_count   (out_count),
        .o_out_escaped (out_escaped),
        .i_limit       (r_limit),
        .i_escape      (escape),
        .o_ctl         (ctl)
    );

    etf_dpath #(
        .FRAC_BITS (FRAC_BITS),
        .MAG_W     (MAG_W)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_ship     (r_ship),
        .i_start_re (i_pix.start_real),
        .i_start_im (i_pix.start_imag),
        .i_const_re (i_pix.const_real),
        .i_const_im (i_pix.const_imag),
        .o_escape   (escape)
    );

    assign i_pix.ready           = in_ready;
    assign o_res.valid           = out_valid;
    assign o_res.iteration_count = out_count;
    assign o_res.escaped         = out_escaped;
endmodule

### dv/tb_escape_time_fractal_iterate_top.sv
// Self-checking testbench for the escape-time fractal iterator top level.
module tb_escape_time_fractal_iterate_top;
    timeunit 1ns;
    timeprecision 1ps;

    import etf_pkg::*;

    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int COUNT_W = COUNT_BITS_DEF;
    localparam int ONE     = 1 << FRAC;
    localparam int FX_MAX  = (1 << (IN_W - 1)) - 1;
    localparam int FX_MIN  = -(1 << (IN_W - 1));
    localparam logic signed [127:0] ESC_RADIUS_SQ = 128'sd4 <<< (2 * FRAC);

    typedef struct {
        logic signed [IN_W-1:0] start_re;
        logic signed [IN_W-1:0] start_im;
        logic signed [IN_W-1:0] c_re;
        logic signed [IN_W-1:0] c_im;
    } t_pixel;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               esc;
    } t_escape;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    t_cfg_reg           cfg_idx;
    logic [COUNT_W-1:0] cfg_data;

    etf_pix_if                          pix_bus ();
    etf_res_if #(.COUNT_BITS(COUNT_W))  res_bus ();

    escape_time_fractal_iterate_top #(
        .FRAC_BITS  (FRAC),
        .COUNT_BITS (COUNT_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_pixel             pixel_q[$];
    t_escape            escape_q[$];
    logic [COUNT_W-1:0] limit_q;
    logic               ship_q;
    int                 queued_cnt   = 0;
    int                 accepted_cnt = 0;
    int                 fail_cnt     = 0;
    int                 src_idle_pct = 0;
    int                 snk_stall_pct = 0;
    logic               pix_taken    = 1'b0;
    logic               hold_off     = 1'b0;
    bit                 pressure_go  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(50_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic t_escape predict_escape(input t_pixel p, input logic [COUNT_W-1:0] lim,
                                               input logic ship);
        logic signed [127:0] re, im, cre, cim, rr, ii, ri, mag;
        t_escape             r;
        int                  i;
        re = 128'(p.start_re);
        im = 128'(p.start_im);
        cre = 128'(p.c_re);
        cim = 128'(p.c_im);
        cre = cre <<< FRAC;
        cim = cim <<< FRAC;
        r.count = lim;
        r.esc = 1'b0;
        for (i = 0; i < int'(lim); i++) begin
            rr = re * re;
            ii = im * im;
            ri = re * im;
            if (ship && ri < 0) ri = -ri;
            re = (rr - ii + cre) >>> FRAC;
            im = (ri + ri + cim) >>> FRAC;
            mag = re * re + im * im;
            if (mag > ESC_RADIUS_SQ) begin
                r.esc = 1'b1;
                r.count = i[COUNT_W-1:0];
                break;
            end
        end
        return r;
    endfunction

    function automatic int rand_coord(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic report_mismatch(input string what);
        fail_cnt++;
        if (fail_cnt <= 100) $display("%0t: %s", $time, what);
    endtask

    task automatic push_pixel(input int sr, input int si, input int cr, input int ci);
        t_pixel p;
        p.start_re = IN_W'(sr);
        p.start_im = IN_W'(si);
        p.c_re = IN_W'(cr);
        p.c_im = IN_W'(ci);
        pixel_q.push_back(p);
        queued_cnt++;
    endtask

    // Mostly well-formed Mandelbrot and Julia points, with some raw bit patterns.
    task automatic push_random_pixel();
        int kind;
        kind = $urandom_range(99);
        if (kind < 15) begin
            push_pixel($urandom, $urandom, $urandom, $urandom);
        end else if (kind < 55) begin
            if ($urandom_range(1)) push_pixel(0, 0,
                rand_coord(-2 * ONE - ONE / 8, ONE / 2 + ONE / 8),
                rand_coord(-ONE - ONE / 4 - ONE / 8, ONE + ONE / 4 + ONE / 8));
            else push_pixel(rand_coord(-ONE / 64, ONE / 64), rand_coord(-ONE / 64, ONE / 64),
                rand_coord(-2 * ONE - ONE / 8, ONE / 2 + ONE / 8),
                rand_coord(-ONE - ONE / 4 - ONE / 8, ONE + ONE / 4 + ONE / 8));
        end else begin
            push_pixel(rand_coord(-2 * ONE, 2 * ONE), rand_coord(-2 * ONE, 2 * ONE),
                       rand_coord(-ONE, ONE), rand_coord(-ONE, ONE));
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [COUNT_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_ITER_LIMIT) limit_q = val;
        else ship_q = val[0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic [COUNT_W-1:0] lim, input logic ship);
        logic [COUNT_W-1:0] val;
        val = COUNT_W'($urandom);
        val[0] = ship;
        write_reg(REG_ITER_LIMIT, lim);
        write_reg(REG_SHIP_MODE, val);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (accepted_cnt != queued_cnt || escape_q.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n, input int lim, input logic ship,
                             input int src_pct, input int snk_pct, input bit squeeze);
        int k;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        set_mode(COUNT_W'(lim), ship);
        for (k = 0; k < n; k++) push_random_pixel();
        if (squeeze) pressure_go = 1'b1;
        drain();
    endtask

    always @(negedge i_clk) begin
        t_pixel nxt;
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else if (!pix_bus.valid || pix_taken) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pixel_q.pop_front();
                pix_bus.valid <= 1'b1;
                pix_bus.start_real <= nxt.start_re;
                pix_bus.start_imag <= nxt.start_im;
                pix_bus.const_real <= nxt.c_re;
                pix_bus.const_imag <= nxt.c_im;
            end else begin
                pix_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) res_bus.ready <= 1'b0;
        else res_bus.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end

    // The sink refuses results for a long stretch so that the block backs up.
    initial begin
        wait (pressure_go);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_pixel seen;
        pix_taken <= i_rst_n && pix_bus.valid && pix_bus.ready;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            seen.start_re = pix_bus.start_real;
            seen.start_im = pix_bus.start_imag;
            seen.c_re = pix_bus.const_real;
            seen.c_im = pix_bus.const_imag;
            escape_q.push_back(predict_escape(seen, limit_q, ship_q));
            accepted_cnt++;
        end
    end

    always @(posedge i_clk) begin
        t_escape want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (escape_q.size() == 0) begin
                report_mismatch("result transaction with no pixel outstanding");
            end else begin
                want = escape_q.pop_front();
                if (res_bus.iteration_count !== want.count)
                    report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                              res_bus.iteration_count, want.count));
                if (res_bus.escaped !== want.esc)
                    report_mismatch($sformatf("escaped %0b, expected %0b",
                                              res_bus.escaped, want.esc));
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.start_real = '0;
        pix_bus.start_imag = '0;
        pix_bus.const_real = '0;
        pix_bus.const_imag = '0;
        res_bus.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_ITER_LIMIT;
        cfg_data = '0;
        limit_q = COUNT_W'(LIMIT_RESET);
        ship_q = SHIP_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: extremes, exact radius boundary, start outside radius.
        push_pixel(0, 0, 0, 0);
        push_pixel(FX_MAX, FX_MAX, FX_MAX, FX_MAX);
        push_pixel(FX_MIN, FX_MIN, FX_MIN, FX_MIN);
        push_pixel(FX_MAX, FX_MIN, FX_MIN, FX_MAX);
        push_pixel(ONE + 3 * ONE / 5, ONE + 3 * ONE / 10, -(7 * ONE / 8), -(4 * ONE - ONE / 10));
        push_pixel(0, 0, 2 * ONE, 0);
        push_pixel(0, 0, -2 * ONE, 0);
        push_pixel(2 * ONE, 0, 0, 0);
        push_pixel(0, 0, ONE / 4, 0);
        push_pixel(0, 0, ONE / 4 + ONE / 100, 0);
        push_pixel(1, -1, -1, 1);
        drain();

        set_mode(COUNT_W'(-1), 1'b1);
        push_pixel(0, 0, 0, 0);
        push_pixel(ONE / 2, -ONE / 2, 0, -ONE / 4);
        push_pixel(-ONE, ONE / 2, -ONE / 2, ONE / 4);
        push_pixel(0, 0, -(7 * ONE / 4), -ONE / 32);
        push_pixel(FX_MIN, FX_MAX, FX_MAX, FX_MIN);
        drain();

        set_mode(COUNT_W'(0), 1'b0);
        push_pixel(0, 0, 0, 0);
        push_pixel(FX_MAX, FX_MAX, FX_MAX, FX_MAX);
        drain();

        set_mode(COUNT_W'(1), 1'b0);
        push_pixel(0, 0, 2 * ONE, 0);
        push_pixel(0, 0, 2 * ONE + 1, 0);
        drain();

        run_phase(150, 20, 1'b0, 0, 0, 1'b0);
        run_phase(150, 50, 1'b1, 82, 0, 1'b0);
        run_phase(150, 1, 1'b0, 0, 82, 1'b0);
        run_phase(150, 100, 1'b0, 27, 27, 1'b0);
        run_phase(120, 7, 1'b1, 0, 0, 1'b1);
        run_phase(100, 255, 1'b1, 82, 82, 1'b0);
        run_phase(60, 1023, 1'b0, 27, 27, 1'b0);
        run_phase(40, 1023, 1'b1, 0, 0, 1'b0);
        run_phase(40, 0, 1'b1, 82, 82, 1'b0);
        run_phase(90, 3, 1'b0, 0, 82, 1'b0);

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/etf_pkg.sv
src/etf_pix_if.sv
src/etf_res_if.sv
src/etf_mult.sv
src/etf_dpath.sv
src/etf_ctrl.sv
src/escape_time_fractal_iterate_top.sv
dv/tb_escape_time_fractal_iterate_top.sv
